// ----- rtl/ir_rct_pkg.sv -----
// ----------------------------------------------------------------------------
// IR remote countdown timer package
// Shared item types, configuration layout, register indexes and command codes.
// ----------------------------------------------------------------------------
package ir_rct_pkg;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int WIDTH_W = 16;
    localparam int FRAME_W = 32;
    localparam int CMD_LSB = 16;
    localparam int INV_LSB = 8;

    localparam logic [2:0] REG_START_MIN = 3'd0;
    localparam logic [2:0] REG_START_MAX = 3'd1;
    localparam logic [2:0] REG_ZERO_MIN  = 3'd2;
    localparam logic [2:0] REG_ZERO_MAX  = 3'd3;
    localparam logic [2:0] REG_ONE_MIN   = 3'd4;
    localparam logic [2:0] REG_ONE_MAX   = 3'd5;

    localparam logic [WIDTH_W-1:0] RST_START_MIN = 16'd8500;
    localparam logic [WIDTH_W-1:0] RST_START_MAX = 16'd9500;
    localparam logic [WIDTH_W-1:0] RST_ZERO_MIN  = 16'd1000;
    localparam logic [WIDTH_W-1:0] RST_ZERO_MAX  = 16'd1500;
    localparam logic [WIDTH_W-1:0] RST_ONE_MIN   = 16'd2000;
    localparam logic [WIDTH_W-1:0] RST_ONE_MAX   = 16'd2600;

    localparam logic [7:0] CMD_RUN     = 8'h40;
    localparam logic [7:0] CMD_INC     = 8'h46;
    localparam logic [7:0] CMD_DEC     = 8'h15;
    localparam logic [7:0] CMD_LOAD_LO = 8'h16;
    localparam logic [7:0] CMD_LOAD_HI = 8'h1C;
    localparam logic [7:0] CMD_CHECK   = 8'hFF;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic [WIDTH_W-1:0] start_min;
        logic [WIDTH_W-1:0] start_max;
        logic [WIDTH_W-1:0] zero_min;
        logic [WIDTH_W-1:0] zero_max;
        logic [WIDTH_W-1:0] one_min;
        logic [WIDTH_W-1:0] one_max;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic               edge_level;
        logic [WIDTH_W-1:0] elapsed_us;
    } item_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] time_left;
        logic               running;
        logic               alarm_on;
        logic               command_valid;
        logic [7:0]         command_code;
        logic               display_changed;
    } result_t;

endpackage

// ----- rtl/ir_remote_countdown_timer_top.sv -----
// ----------------------------------------------------------------------------
// IR remote countdown timer
// Every accepted item (a receiver pin edge or a countdown tick) produces
// exactly one result item. The block takes one item per clock cycle: an item
// is held in the input register, the decoder and countdown update in a
// single pass, and the result sits in the output register until taken, so
// result_valid rises when the output register is loaded from the item
// held in the input register. Only a stalled result channel slows the
// input side.
// ----------------------------------------------------------------------------
module ir_remote_countdown_timer_top #(
    parameter int FRAME_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  ir_rct_pkg::item_t             item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output ir_rct_pkg::result_t           result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ir_rct_pkg::ADDR_W-1:0] paddr,
    input  logic [ir_rct_pkg::DATA_W-1:0] pwdata,
    output logic [ir_rct_pkg::DATA_W-1:0] prdata,
    output logic                          pready
);

    ir_rct_pkg::cfg_t    cfg;
    ir_rct_pkg::item_t   item_reg;
    logic                in_valid_reg;
    ir_rct_pkg::result_t result_reg;
    ir_rct_pkg::result_t result_next;
    logic                result_valid_reg;
    logic                advance;

    assign advance      = in_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    ir_rct_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ir_rct_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (item_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- rtl/ir_rct_regs.sv -----
// ----------------------------------------------------------------------------
// IR remote countdown timer register file
// APB-style access to the six pulse window bounds.
// ----------------------------------------------------------------------------
module ir_rct_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ir_rct_pkg::ADDR_W-1:0] paddr,
    input  logic [ir_rct_pkg::DATA_W-1:0] pwdata,
    output logic [ir_rct_pkg::DATA_W-1:0] prdata,
    output logic                          pready,
    output ir_rct_pkg::cfg_t              cfg
);

    ir_rct_pkg::cfg_t cfg_reg;
    logic [2:0]       reg_index;
    logic             wr_en;
    logic [ir_rct_pkg::WIDTH_W-1:0] wdata;
    logic [ir_rct_pkg::WIDTH_W-1:0] rdata;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign wdata     = pwdata[ir_rct_pkg::WIDTH_W-1:0];
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_min <= ir_rct_pkg::RST_START_MIN;
            cfg_reg.start_max <= ir_rct_pkg::RST_START_MAX;
            cfg_reg.zero_min  <= ir_rct_pkg::RST_ZERO_MIN;
            cfg_reg.zero_max  <= ir_rct_pkg::RST_ZERO_MAX;
            cfg_reg.one_min   <= ir_rct_pkg::RST_ONE_MIN;
            cfg_reg.one_max   <= ir_rct_pkg::RST_ONE_MAX;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                ir_rct_pkg::REG_START_MIN: cfg_reg.start_min <= wdata;
                ir_rct_pkg::REG_START_MAX: cfg_reg.start_max <= wdata;
                ir_rct_pkg::REG_ZERO_MIN:  cfg_reg.zero_min  <= wdata;
                ir_rct_pkg::REG_ZERO_MAX:  cfg_reg.zero_max  <= wdata;
                ir_rct_pkg::REG_ONE_MIN:   cfg_reg.one_min   <= wdata;
                ir_rct_pkg::REG_ONE_MAX:   cfg_reg.one_max   <= wdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            ir_rct_pkg::REG_START_MIN: rdata = cfg_reg.start_min;
            ir_rct_pkg::REG_START_MAX: rdata = cfg_reg.start_max;
            ir_rct_pkg::REG_ZERO_MIN:  rdata = cfg_reg.zero_min;
            ir_rct_pkg::REG_ZERO_MAX:  rdata = cfg_reg.zero_max;
            ir_rct_pkg::REG_ONE_MIN:   rdata = cfg_reg.one_min;
            ir_rct_pkg::REG_ONE_MAX:   rdata = cfg_reg.one_max;
            default:                   rdata = '0;
        endcase
    end

    assign prdata = {{(ir_rct_pkg::DATA_W - ir_rct_pkg::WIDTH_W){1'b0}}, rdata};

endmodule

// ----- rtl/ir_rct_core.sv -----
// ----------------------------------------------------------------------------
// IR remote countdown timer core
// Frame decoder and countdown state, updated once for each item stepped in.
// ----------------------------------------------------------------------------
module ir_rct_core #(
    parameter int FRAME_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  ir_rct_pkg::item_t   item,
    input  ir_rct_pkg::cfg_t    cfg,
    output ir_rct_pkg::result_t result_next
);

    localparam int CNT_W = $clog2(FRAME_BITS + 1);

    logic [ir_rct_pkg::WIDTH_W-1:0] last_width_reg, last_width_next;
    logic                           in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]               bit_count_reg, bit_count_next;
    logic [ir_rct_pkg::FRAME_W-1:0] frame_bits_reg, frame_bits_next;
    logic [ir_rct_pkg::WIDTH_W-1:0] countdown_reg, countdown_next;
    logic                           run_reg, run_next;
    logic                           alarm_reg, alarm_next;

    logic                           cmd_valid;
    logic [7:0]                     cmd_code;
    logic                           redraw;
    logic [ir_rct_pkg::FRAME_W-1:0] shifted;
    logic [CNT_W-1:0]               count_inc;
    logic [7:0]                     cmd;
    logic [7:0]                     inv;
    logic [ir_rct_pkg::WIDTH_W-1:0] count_dec;

    function automatic logic in_window(
        input logic [ir_rct_pkg::WIDTH_W-1:0] v,
        input logic [ir_rct_pkg::WIDTH_W-1:0] lo,
        input logic [ir_rct_pkg::WIDTH_W-1:0] hi
    );
        return (v > lo) && (v < hi);
    endfunction

    always_comb
    begin
        last_width_next = last_width_reg;
        in_frame_next   = in_frame_reg;
        bit_count_next  = bit_count_reg;
        frame_bits_next = frame_bits_reg;
        countdown_next  = countdown_reg;
        run_next        = run_reg;
        alarm_next      = alarm_reg;
        cmd_valid       = 1'b0;
        cmd_code        = '0;
        redraw          = 1'b0;

        if (in_window(last_width_reg, cfg.zero_min, cfg.zero_max))
        begin
            shifted = {frame_bits_reg[ir_rct_pkg::FRAME_W-2:0], 1'b0};
        end
        else if (in_window(last_width_reg, cfg.one_min, cfg.one_max))
        begin
            shifted = {frame_bits_reg[ir_rct_pkg::FRAME_W-2:0], 1'b1};
        end
        else
        begin
            shifted = frame_bits_reg;
        end
        count_inc = bit_count_reg + 1'b1;
        cmd       = shifted[ir_rct_pkg::CMD_LSB +: 8];
        inv       = shifted[ir_rct_pkg::INV_LSB +: 8];
        count_dec = countdown_reg - 1'b1;

        if (item.kind == ir_rct_pkg::KIND_TICK)
        begin
            if (run_reg && (countdown_reg != '0))
            begin
                countdown_next = count_dec;
                redraw         = 1'b1;
                if (count_dec == '0)
                begin
                    alarm_next = 1'b1;
                    run_next   = 1'b0;
                end
            end
        end
        else if (item.edge_level)
        begin
            last_width_next = item.elapsed_us;
        end
        else if (!in_frame_reg)
        begin
            if (in_window(last_width_reg, cfg.start_min, cfg.start_max))
            begin
                in_frame_next   = 1'b1;
                bit_count_next  = '0;
                frame_bits_next = '0;
            end
        end
        else
        begin
            frame_bits_next = shifted;
            bit_count_next  = count_inc;
            if (count_inc == CNT_W'(FRAME_BITS))
            begin
                in_frame_next = 1'b0;
                if ((cmd ^ inv) == ir_rct_pkg::CMD_CHECK)
                begin
                    cmd_valid = 1'b1;
                    cmd_code  = cmd;
                    case (cmd) inside
                        ir_rct_pkg::CMD_RUN:
                        begin
                            run_next = !run_reg;
                        end
                        ir_rct_pkg::CMD_INC:
                        begin
                            countdown_next = countdown_reg + 1'b1;
                            redraw         = 1'b1;
                        end
                        ir_rct_pkg::CMD_DEC:
                        begin
                            if (countdown_reg != '0)
                            begin
                                countdown_next = count_dec;
                            end
                            redraw = 1'b1;
                        end
                        [ir_rct_pkg::CMD_LOAD_LO:ir_rct_pkg::CMD_LOAD_HI]:
                        begin
                            countdown_next = ir_rct_pkg::WIDTH_W'(cmd - ir_rct_pkg::CMD_LOAD_LO);
                            redraw         = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        result_next.time_left       = countdown_next;
        result_next.running         = run_next;
        result_next.alarm_on        = alarm_next;
        result_next.command_valid   = cmd_valid;
        result_next.command_code    = cmd_code;
        result_next.display_changed = redraw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_width_reg <= '0;
            in_frame_reg   <= 1'b0;
            bit_count_reg  <= '0;
            frame_bits_reg <= '0;
            countdown_reg  <= '0;
            run_reg        <= 1'b0;
            alarm_reg      <= 1'b0;
        end
        else if (step)
        begin
            last_width_reg <= last_width_next;
            in_frame_reg   <= in_frame_next;
            bit_count_reg  <= bit_count_next;
            frame_bits_reg <= frame_bits_next;
            countdown_reg  <= countdown_next;
            run_reg        <= run_next;
            alarm_reg      <= alarm_next;
        end
    end

    // The alarm is sticky until reset.
    assert property (@(posedge clk) disable iff (!rst_n) alarm_reg |=> alarm_reg)
        else $error("alarm flag cleared without reset");

    // An open frame never holds a full bit count.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (bit_count_reg < CNT_W'(FRAME_BITS)))
        else $error("frame bit count overran the frame length");

    // A command is reported only when an open frame is being closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && cmd_valid) |-> (in_frame_reg && !in_frame_next))
        else $error("command reported outside a closing frame");

endmodule
